### hw/rtl/ptbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptbw_pkg
// Types and fixed widths shared by the barycentric weight pipeline.
// ----------------------------------------------------------------------------
package ptbw_pkg;

    localparam int CW = 16;              // coordinate width, Q8.8
    localparam int DW = CW + 1;          // edge vector width
    localparam int PW = 2 * DW;          // product width
    localparam int XW = PW + 1;          // cross product width
    localparam int NW = PW + 2;          // summed numerator width
    localparam int FB = 16;              // weight fraction bits
    localparam int WW = FB + 4;          // weight width
    localparam int QS = FB + 7;          // quotient bits (one extra for rounding)
    localparam int SH = QS - FB - 1;     // divisor pre-shift
    localparam int RW = NW + SH;         // remainder width
    localparam int VW = QS + 2;          // signed quotient width

    localparam logic [2:0] REG_AX = 3'd0;
    localparam logic [2:0] REG_AY = 3'd1;
    localparam logic [2:0] REG_BX = 3'd2;
    localparam logic [2:0] REG_BY = 3'd3;
    localparam logic [2:0] REG_CX = 3'd4;
    localparam logic [2:0] REG_CY = 3'd5;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
    } t_in;

    typedef struct packed {
        logic signed [WW-1:0] weight_a;
        logic signed [WW-1:0] weight_b;
        logic signed [WW-1:0] weight_c;
        logic                 inside_res;
        logic                 degenerate;
        logic                 saturated;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
    } t_tri;

    typedef struct packed {
        logic signed [NW-1:0] nb;
        logic signed [NW-1:0] nc;
        logic signed [NW-1:0] ns;
        logic signed [XW-1:0] det;
    } t_cross;

    typedef struct packed {
        logic neg_b;
        logic neg_c;
        logic neg_s;
        logic ovf_b;
        logic ovf_c;
        logic ovf_s;
        logic degen;
    } t_ctl;

endpackage

### hw/rtl/ptbw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptbw_front
// Edge vectors, products and cross products over three register stages.
// ----------------------------------------------------------------------------
module ptbw_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ptbw_pkg::t_in         i_point,
    input  ptbw_pkg::t_tri        i_tri,
    output logic                  o_valid,
    output ptbw_pkg::t_cross      o_cross
);

    logic                              r_v1, r_v2, r_v3;
    logic signed [ptbw_pkg::DW-1:0]    r_e0x, r_e0y, r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [ptbw_pkg::PW-1:0]    r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    ptbw_pkg::t_cross                  r_cross;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e0x <= ptbw_pkg::DW'(i_point.point_x) - ptbw_pkg::DW'(i_tri.ax);
        r_e0y <= ptbw_pkg::DW'(i_point.point_y) - ptbw_pkg::DW'(i_tri.ay);
        r_e1x <= ptbw_pkg::DW'(i_tri.bx) - ptbw_pkg::DW'(i_tri.ax);
        r_e1y <= ptbw_pkg::DW'(i_tri.by) - ptbw_pkg::DW'(i_tri.ay);
        r_e2x <= ptbw_pkg::DW'(i_tri.cx) - ptbw_pkg::DW'(i_tri.ax);
        r_e2y <= ptbw_pkg::DW'(i_tri.cy) - ptbw_pkg::DW'(i_tri.ay);

        r_p0 <= ptbw_pkg::PW'(r_e0x) * ptbw_pkg::PW'(r_e2y);
        r_p1 <= ptbw_pkg::PW'(r_e0y) * ptbw_pkg::PW'(r_e2x);
        r_p2 <= ptbw_pkg::PW'(r_e1x) * ptbw_pkg::PW'(r_e0y);
        r_p3 <= ptbw_pkg::PW'(r_e1y) * ptbw_pkg::PW'(r_e0x);
        r_p4 <= ptbw_pkg::PW'(r_e1x) * ptbw_pkg::PW'(r_e2y);
        r_p5 <= ptbw_pkg::PW'(r_e1y) * ptbw_pkg::PW'(r_e2x);

        r_cross.nb  <= ptbw_pkg::NW'(r_p0) - ptbw_pkg::NW'(r_p1);
        r_cross.nc  <= ptbw_pkg::NW'(r_p2) - ptbw_pkg::NW'(r_p3);
        r_cross.ns  <= ptbw_pkg::NW'(r_p0) - ptbw_pkg::NW'(r_p1)
                     + ptbw_pkg::NW'(r_p2) - ptbw_pkg::NW'(r_p3);
        r_cross.det <= ptbw_pkg::XW'(r_p4) - ptbw_pkg::XW'(r_p5);
    end

    assign o_valid = r_v3;
    assign o_cross = r_cross;

endmodule

### hw/rtl/ptbw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptbw_div
// Pipelined restoring fractional divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptbw_div (
    input  logic                     i_clk,
    input  logic [ptbw_pkg::RW-1:0]  i_num,
    input  logic [ptbw_pkg::RW-1:0]  i_den,
    output logic [ptbw_pkg::QS-1:0]  o_quo
);

    logic [ptbw_pkg::RW-1:0] r_rem [ptbw_pkg::QS];
    logic [ptbw_pkg::RW-1:0] r_den [ptbw_pkg::QS];
    logic [ptbw_pkg::QS-1:0] r_quo [ptbw_pkg::QS];
    logic [ptbw_pkg::RW-1:0] n_rem [ptbw_pkg::QS];
    logic [ptbw_pkg::RW-1:0] n_den [ptbw_pkg::QS];
    logic [ptbw_pkg::QS-1:0] n_quo [ptbw_pkg::QS];

    always_comb begin
        logic [ptbw_pkg::RW-1:0] src_rem;
        logic [ptbw_pkg::QS-1:0] src_quo;
        logic [ptbw_pkg::RW-1:0] dbl;
        logic [ptbw_pkg::RW:0]   diff;
        for (int k = 0; k < ptbw_pkg::QS; k++) begin
            src_rem  = (k == 0) ? i_num : r_rem[(k == 0) ? 0 : k - 1];
            src_quo  = (k == 0) ? '0 : r_quo[(k == 0) ? 0 : k - 1];
            n_den[k] = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            dbl      = {src_rem[ptbw_pkg::RW-2:0], 1'b0};
            diff     = {1'b0, dbl} - {1'b0, n_den[k]};
            n_rem[k] = diff[ptbw_pkg::RW] ? dbl : diff[ptbw_pkg::RW-1:0];
            n_quo[k] = {src_quo[ptbw_pkg::QS-2:0], ~diff[ptbw_pkg::RW]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_quo = r_quo[ptbw_pkg::QS-1];

endmodule

### hw/rtl/point_to_barycentric_weights.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_barycentric_weights
// Barycentric weights of a point against a triangle held in registers.
// ----------------------------------------------------------------------------
// One point is taken every clock cycle and busy never rises. Each result
// leaves on o_result with o_valid high for one cycle. A point passes
// through edge vectors, products and cross products, then a register of
// magnitude and range check, the bit-per-stage divider and an output
// register. The receiver cannot stall the block.
// Vertex registers may only be written while no point is in flight.
// ----------------------------------------------------------------------------
module point_to_barycentric_weights (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  ptbw_pkg::t_in           i_point,
    output logic                    o_valid,
    output ptbw_pkg::t_out          o_result,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [ptbw_pkg::CW-1:0] i_cfg_data
);

    localparam logic signed [ptbw_pkg::VW:0] ONE  = (ptbw_pkg::VW + 1)'(1 << ptbw_pkg::FB);
    localparam logic signed [ptbw_pkg::VW:0] WMAX =
        (ptbw_pkg::VW + 1)'((1 << (ptbw_pkg::WW - 1)) - 1);
    localparam logic signed [ptbw_pkg::VW:0] WMIN =
        -(ptbw_pkg::VW + 1)'(1 << (ptbw_pkg::WW - 1));

    ptbw_pkg::t_tri              r_tri;
    logic                        w_fv;
    ptbw_pkg::t_cross            w_cross;
    logic                        r_v4;
    logic [ptbw_pkg::RW-1:0]     r_mb, r_mc, r_ms, r_t;
    ptbw_pkg::t_ctl              r_ctl;
    ptbw_pkg::t_ctl              n_ctl;
    logic [ptbw_pkg::RW-1:0]     n_mb, n_mc, n_ms, n_t;
    logic                        r_vdly [ptbw_pkg::QS];
    ptbw_pkg::t_ctl              r_cdly [ptbw_pkg::QS];
    logic [ptbw_pkg::QS-1:0]     w_qb, w_qc, w_qs;
    logic                        r_ov;
    ptbw_pkg::t_out              r_out, n_out;

    assign busy = 1'b0;

    // vertex registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptbw_pkg::REG_AX: r_tri.ax <= i_cfg_data;
                ptbw_pkg::REG_AY: r_tri.ay <= i_cfg_data;
                ptbw_pkg::REG_BX: r_tri.bx <= i_cfg_data;
                ptbw_pkg::REG_BY: r_tri.by <= i_cfg_data;
                ptbw_pkg::REG_CX: r_tri.cx <= i_cfg_data;
                ptbw_pkg::REG_CY: r_tri.cy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ptbw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_point (i_point),
        .i_tri   (r_tri),
        .o_valid (w_fv),
        .o_cross (w_cross)
    );

    // magnitudes, signs and range check
    always_comb begin
        logic [ptbw_pkg::NW-1:0] ab, ac, as;
        logic [ptbw_pkg::XW-1:0] ad;
        ab = w_cross.nb[ptbw_pkg::NW-1] ? -w_cross.nb : w_cross.nb;
        ac = w_cross.nc[ptbw_pkg::NW-1] ? -w_cross.nc : w_cross.nc;
        as = w_cross.ns[ptbw_pkg::NW-1] ? -w_cross.ns : w_cross.ns;
        ad = w_cross.det[ptbw_pkg::XW-1] ? -w_cross.det : w_cross.det;
        n_mb = ptbw_pkg::RW'(ab);
        n_mc = ptbw_pkg::RW'(ac);
        n_ms = ptbw_pkg::RW'(as);
        n_t  = ptbw_pkg::RW'(ad) << ptbw_pkg::SH;
        n_ctl.neg_b = w_cross.nb[ptbw_pkg::NW-1] ^ w_cross.det[ptbw_pkg::XW-1];
        n_ctl.neg_c = w_cross.nc[ptbw_pkg::NW-1] ^ w_cross.det[ptbw_pkg::XW-1];
        n_ctl.neg_s = w_cross.ns[ptbw_pkg::NW-1] ^ w_cross.det[ptbw_pkg::XW-1];
        n_ctl.ovf_b = (n_mb >= n_t);
        n_ctl.ovf_c = (n_mc >= n_t);
        n_ctl.ovf_s = (n_ms >= n_t);
        n_ctl.degen = (w_cross.det == '0);
    end

    always_ff @(posedge i_clk) begin
        r_mb  <= n_mb;
        r_mc  <= n_mc;
        r_ms  <= n_ms;
        r_t   <= n_t;
        r_ctl <= n_ctl;
    end

    ptbw_div u_div_b (.i_clk(i_clk), .i_num(r_mb), .i_den(r_t), .o_quo(w_qb));
    ptbw_div u_div_c (.i_clk(i_clk), .i_num(r_mc), .i_den(r_t), .o_quo(w_qc));
    ptbw_div u_div_s (.i_clk(i_clk), .i_num(r_ms), .i_den(r_t), .o_quo(w_qs));

    // valid and control follow the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k < ptbw_pkg::QS; k++) begin
                r_vdly[k] <= 1'b0;
            end
        end else begin
            r_v4 <= w_fv;
            r_ov <= r_vdly[ptbw_pkg::QS-1];
            r_vdly[0] <= r_v4;
            for (int k = 1; k < ptbw_pkg::QS; k++) begin
                r_vdly[k] <= r_vdly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cdly[0] <= r_ctl;
        for (int k = 1; k < ptbw_pkg::QS; k++) begin
            r_cdly[k] <= r_cdly[k-1];
        end
    end

    function automatic logic signed [ptbw_pkg::VW:0] signed_quo(
        input logic [ptbw_pkg::QS-1:0] q,
        input logic                    ovf,
        input logic                    neg
    );
        logic [ptbw_pkg::QS:0]          rnd;
        logic [ptbw_pkg::QS-1:0]        mag;
        logic signed [ptbw_pkg::VW:0]   v;
        rnd = {1'b0, q} + (ptbw_pkg::QS + 1)'(1);
        mag = ovf ? '1 : rnd[ptbw_pkg::QS:1];
        v   = $signed({3'b000, mag});
        return neg ? -v : v;
    endfunction

    // final rounding, sign, clamp, inside test and degenerate case
    always_comb begin
        ptbw_pkg::t_ctl                 c;
        logic signed [ptbw_pkg::VW:0]   vb, vc, vs, va;
        logic                           sat;
        c   = r_cdly[ptbw_pkg::QS-1];
        vb  = signed_quo(w_qb, c.ovf_b, c.neg_b);
        vc  = signed_quo(w_qc, c.ovf_c, c.neg_c);
        vs  = signed_quo(w_qs, c.ovf_s, c.neg_s);
        va  = ONE - vs;
        sat = 1'b0;
        if (vb > WMAX) begin
            vb = WMAX; sat = 1'b1;
        end else if (vb < WMIN) begin
            vb = WMIN; sat = 1'b1;
        end
        if (vc > WMAX) begin
            vc = WMAX; sat = 1'b1;
        end else if (vc < WMIN) begin
            vc = WMIN; sat = 1'b1;
        end
        if (va > WMAX) begin
            va = WMAX; sat = 1'b1;
        end else if (va < WMIN) begin
            va = WMIN; sat = 1'b1;
        end
        if (c.degen) begin
            n_out = '0;
            n_out.degenerate = 1'b1;
            n_out.inside_res = 1'b1;
        end else begin
            n_out.weight_a   = va[ptbw_pkg::WW-1:0];
            n_out.weight_b   = vb[ptbw_pkg::WW-1:0];
            n_out.weight_c   = vc[ptbw_pkg::WW-1:0];
            n_out.degenerate = 1'b0;
            n_out.saturated  = sat;
            n_out.inside_res = ~va[ptbw_pkg::WW-1] & ~vb[ptbw_pkg::WW-1]
                             & ~vc[ptbw_pkg::WW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

endmodule
